// ===== sv/fntt_pkg.sv =====
// Package for the forward NTT unit over Z_3329.
// Holds the request/response structs, command codes, sequencer states and the twiddle table.
// No dependencies.
package fntt_pkg;

   localparam int unsigned NUM_COEFS = 256;
   localparam int unsigned ADDR_W    = 8;
   localparam int unsigned COEF_W    = 12;
   localparam int unsigned NUM_ZETAS = 128;
   localparam int unsigned LAYER_W   = 3;
   localparam int unsigned BFLY_W    = 7;
   localparam int unsigned PROD_W    = 2 * COEF_W;

   // modulus and Barrett constant floor(2^32 / 3329)
   localparam logic [12:0] MODQ          = 13'd3329;
   localparam logic [20:0] BARRETT_M     = 21'd1290167;
   localparam int unsigned BARRETT_SHIFT = 32;

   localparam logic [LAYER_W-1:0] LAST_LAYER = 3'd6;

   // command codes; code 3 is accepted and ignored
   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_RUN   = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [ADDR_W-1:0] index;
      logic [COEF_W-1:0] coef_in;
   } req_type;

   typedef struct packed {
      logic [COEF_W-1:0] coef_out;
      logic              is_done;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_BF_RD,
      ST_BF_MUL,
      ST_BF_BAR,
      ST_BF_RED,
      ST_BF_WRB,
      ST_BF_WRA
   } state_type;

   // 17^BitRev7(k) mod 3329, k = 0..127
   localparam logic [COEF_W-1:0] ZETAS [NUM_ZETAS] = '{
      12'd1,    12'd1729, 12'd2580, 12'd3289, 12'd2642, 12'd630,  12'd1897, 12'd848,
      12'd1062, 12'd1919, 12'd193,  12'd797,  12'd2786, 12'd3260, 12'd569,  12'd1746,
      12'd296,  12'd2447, 12'd1339, 12'd1476, 12'd3046, 12'd56,   12'd2240, 12'd1333,
      12'd1426, 12'd2094, 12'd535,  12'd2882, 12'd2393, 12'd2879, 12'd1974, 12'd821,
      12'd289,  12'd331,  12'd3253, 12'd1756, 12'd1197, 12'd2304, 12'd2277, 12'd2055,
      12'd650,  12'd1977, 12'd2513, 12'd632,  12'd2865, 12'd33,   12'd1320, 12'd1915,
      12'd2319, 12'd1435, 12'd807,  12'd452,  12'd1438, 12'd2868, 12'd1534, 12'd2402,
      12'd2647, 12'd2617, 12'd1481, 12'd648,  12'd2474, 12'd3110, 12'd1227, 12'd910,
      12'd17,   12'd2761, 12'd583,  12'd2649, 12'd1637, 12'd723,  12'd2288, 12'd1100,
      12'd1409, 12'd2662, 12'd3281, 12'd233,  12'd756,  12'd2156, 12'd3015, 12'd3050,
      12'd1703, 12'd1651, 12'd2789, 12'd1789, 12'd1847, 12'd952,  12'd1461, 12'd2687,
      12'd939,  12'd2308, 12'd2437, 12'd2388, 12'd733,  12'd2337, 12'd268,  12'd641,
      12'd1584, 12'd2298, 12'd2037, 12'd3220, 12'd375,  12'd2549, 12'd2090, 12'd1645,
      12'd1063, 12'd319,  12'd2773, 12'd757,  12'd2099, 12'd561,  12'd2466, 12'd2594,
      12'd2804, 12'd1092, 12'd403,  12'd1026, 12'd1143, 12'd2150, 12'd2775, 12'd886,
      12'd1722, 12'd1212, 12'd1874, 12'd1029, 12'd2110, 12'd2935, 12'd885,  12'd2154
   };

endpackage

// ===== sv/forward_ntt_mod_3329_unit.sv =====
// Forward NTT unit over Z_3329: 256-entry coefficient store, one shared butterfly datapath
// and the sequencer that walks the seven Cooley-Tukey layers.
// Depends on fntt_pkg.
//
//   channel    ports                    direction  transfer when
//   request    start, busy, req_data    in         start high and busy low at the edge
//   response   rsp_strobe, rsp_data     out        every cycle rsp_strobe is high
//
// Sequencing: a write frees the unit at once; a read keeps busy high through ST_READ, and its
// result is shown as busy drops. A run takes one butterfly at a time through BF_RD, BF_MUL,
// BF_BAR, BF_RED, BF_WRB and BF_WRA, using the single multiply/Barrett/add datapath and the
// two-read, one-write store: 7 layers x 128 butterflies, then the done result.
// Reset: a clearing sweep writes zero to all 256 entries, one a cycle; busy stays high until
// the sweep ends. The response side cannot stall; each result is shown for one cycle.
module forward_ntt_mod_3329_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  fntt_pkg::req_type req_data,
   output logic             rsp_strobe,
   output fntt_pkg::rsp_type rsp_data
);

   // coefficient store, two registered read ports, one write port
   logic [fntt_pkg::COEF_W-1:0] coef_mem [fntt_pkg::NUM_COEFS];
   logic [fntt_pkg::COEF_W-1:0] rd_a_ff, rd_b_ff;
   logic [fntt_pkg::ADDR_W-1:0] rd_addr_a, rd_addr_b;
   logic                        mem_we;
   logic [fntt_pkg::ADDR_W-1:0] mem_waddr;
   logic [fntt_pkg::COEF_W-1:0] mem_wdata;

   // sequencer state
   fntt_pkg::state_type          state_ff, state_in;
   logic [fntt_pkg::ADDR_W-1:0]  clr_ff, clr_in;
   logic [fntt_pkg::LAYER_W-1:0] layer_ff, layer_in;
   logic [fntt_pkg::BFLY_W-1:0]  bf_ff, bf_in;
   logic                         rsp_strobe_ff, rsp_strobe_in;

   // butterfly datapath registers
   logic [fntt_pkg::ADDR_W-1:0] addr_a_ff, addr_a_in, addr_b_ff, addr_b_in;
   logic [fntt_pkg::COEF_W-1:0] zeta_ff, zeta_in;
   logic [fntt_pkg::COEF_W-1:0] a_ff, a_in;
   logic [fntt_pkg::PROD_W-1:0] p_ff, p_in;
   logic [fntt_pkg::COEF_W-1:0] qe_ff, qe_in;
   logic [fntt_pkg::COEF_W-1:0] t_ff, t_in;
   fntt_pkg::rsp_type           rsp_ff, rsp_in;

   logic                          accept;
   logic [fntt_pkg::BFLY_W-1:0]   lo_mask;
   logic [fntt_pkg::ADDR_W-1:0]   len8, bf_j;
   logic [fntt_pkg::BFLY_W-1:0]   zeta_idx;
   logic [12:0]                   wr_ext, sum13, diff13, red13;
   logic [fntt_pkg::COEF_W-1:0]   wr_reduced, sum_mod, diff_mod;
   logic [44:0]                   bar_prod;
   logic [fntt_pkg::PROD_W-1:0]   red_diff;

   assign busy   = (state_ff != fntt_pkg::ST_IDLE);
   assign accept = start && !busy;

   // reduce a written coefficient: values below 4096 need one subtract at most
   assign wr_ext     = {1'b0, req_data.coef_in};
   assign wr_reduced = (wr_ext >= fntt_pkg::MODQ) ? 12'(wr_ext - fntt_pkg::MODQ)
                                                  : req_data.coef_in;

   // butterfly addressing: len = 128 >> layer, insert a zero bit at the len position of bf
   assign lo_mask  = 7'h7f >> layer_ff;
   assign len8     = 8'h80 >> layer_ff;
   assign bf_j     = {bf_ff & ~lo_mask, 1'b0} | {1'b0, bf_ff & lo_mask};
   assign zeta_idx = (7'h01 << layer_ff) | (bf_ff >> (3'd7 - layer_ff));

   // modular multiply: product, Barrett quotient estimate, then one correction
   assign bar_prod = {21'b0, p_ff} * {24'b0, fntt_pkg::BARRETT_M};
   assign red_diff = p_ff - ({12'b0, qe_ff} * {11'b0, fntt_pkg::MODQ});
   assign red13    = red_diff[12:0];

   // butterfly add and subtract mod q
   assign sum13    = {1'b0, a_ff} + {1'b0, t_ff};
   assign sum_mod  = (sum13 >= fntt_pkg::MODQ) ? 12'(sum13 - fntt_pkg::MODQ) : sum13[11:0];
   assign diff13   = {1'b0, a_ff} + fntt_pkg::MODQ - {1'b0, t_ff};
   assign diff_mod = (a_ff >= t_ff) ? (a_ff - t_ff) : diff13[11:0];

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      layer_in      = layer_ff;
      bf_in         = bf_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      addr_a_in     = addr_a_ff;
      addr_b_in     = addr_b_ff;
      zeta_in       = zeta_ff;
      a_in          = a_ff;
      p_in          = p_ff;
      qe_in         = qe_ff;
      t_in          = t_ff;
      mem_we        = 1'b0;
      mem_waddr     = addr_a_ff;
      mem_wdata     = sum_mod;
      rd_addr_a     = req_data.index;
      rd_addr_b     = bf_j | len8;

      unique case (state_ff)
         fntt_pkg::ST_CLEAR: begin
            // sweep zeros through the store after reset
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + 8'd1;
            if (clr_ff == '1) begin
               state_in = fntt_pkg::ST_IDLE;
            end
         end
         fntt_pkg::ST_IDLE: begin
            if (accept) begin
               unique case (req_data.cmd)
                  fntt_pkg::CMD_WRITE: begin
                     mem_we    = 1'b1;
                     mem_waddr = req_data.index;
                     mem_wdata = wr_reduced;
                  end
                  fntt_pkg::CMD_RUN: begin
                     layer_in = '0;
                     bf_in    = '0;
                     state_in = fntt_pkg::ST_BF_RD;
                  end
                  fntt_pkg::CMD_READ: begin
                     state_in = fntt_pkg::ST_READ;
                  end
                  default: begin
                     // unused code: drop the transfer
                  end
               endcase
            end
         end
         fntt_pkg::ST_READ: begin
            rsp_strobe_in   = 1'b1;
            rsp_in.coef_out = rd_a_ff;
            rsp_in.is_done  = 1'b0;
            state_in        = fntt_pkg::ST_IDLE;
         end
         fntt_pkg::ST_BF_RD: begin
            // fetch both operands and latch this butterfly's addresses and twiddle
            rd_addr_a = bf_j;
            addr_a_in = bf_j;
            addr_b_in = bf_j | len8;
            zeta_in   = fntt_pkg::ZETAS[zeta_idx];
            state_in  = fntt_pkg::ST_BF_MUL;
         end
         fntt_pkg::ST_BF_MUL: begin
            a_in     = rd_a_ff;
            p_in     = {12'b0, zeta_ff} * {12'b0, rd_b_ff};
            state_in = fntt_pkg::ST_BF_BAR;
         end
         fntt_pkg::ST_BF_BAR: begin
            qe_in    = bar_prod[fntt_pkg::BARRETT_SHIFT +: fntt_pkg::COEF_W];
            state_in = fntt_pkg::ST_BF_RED;
         end
         fntt_pkg::ST_BF_RED: begin
            t_in     = (red13 >= fntt_pkg::MODQ) ? 12'(red13 - fntt_pkg::MODQ) : red13[11:0];
            state_in = fntt_pkg::ST_BF_WRB;
         end
         fntt_pkg::ST_BF_WRB: begin
            mem_we    = 1'b1;
            mem_waddr = addr_b_ff;
            mem_wdata = diff_mod;
            state_in  = fntt_pkg::ST_BF_WRA;
         end
         fntt_pkg::ST_BF_WRA: begin
            mem_we    = 1'b1;
            mem_waddr = addr_a_ff;
            mem_wdata = sum_mod;
            // advance to the next butterfly, the next layer, or finish the run
            if (bf_ff == '1) begin
               bf_in = '0;
               if (layer_ff == fntt_pkg::LAST_LAYER) begin
                  rsp_strobe_in   = 1'b1;
                  rsp_in.coef_out = '0;
                  rsp_in.is_done  = 1'b1;
                  state_in        = fntt_pkg::ST_IDLE;
               end else begin
                  layer_in = layer_ff + 3'd1;
                  state_in = fntt_pkg::ST_BF_RD;
               end
            end else begin
               bf_in    = bf_ff + 7'd1;
               state_in = fntt_pkg::ST_BF_RD;
            end
         end
         default: begin
            state_in = fntt_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fntt_pkg::ST_CLEAR;
         clr_ff        <= '0;
         layer_ff      <= '0;
         bf_ff         <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         layer_ff      <= layer_in;
         bf_ff         <= bf_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      addr_a_ff <= addr_a_in;
      addr_b_ff <= addr_b_in;
      zeta_ff   <= zeta_in;
      a_ff      <= a_in;
      p_ff      <= p_in;
      qe_ff     <= qe_in;
      t_ff      <= t_in;
      rsp_ff    <= rsp_in;
   end

   // store: write port and two registered read ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         coef_mem[mem_waddr] <= mem_wdata;
      end
      rd_a_ff <= coef_mem[rd_addr_a];
      rd_b_ff <= coef_mem[rd_addr_b];
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ===== tb/sv/forward_ntt_mod_3329_unit_tb.sv =====
// Self-checking testbench for forward_ntt_mod_3329_unit: coefficient loads, transform runs and
// read-back are predicted by a local model of the 256-entry store and the seven-layer NTT.
// Depends on fntt_pkg and the unit itself.
module forward_ntt_mod_3329_unit_tb;

   localparam int          Q_MOD        = 3329;
   localparam logic [1:0]  CMD_UNUSED   = 2'd3;
   localparam int          RANDOM_ITEMS = 1275;
   localparam int          RUN_CYCLES   = 5376 + 16;
   localparam int          REPORT_MAX   = 10;

   // one planned transfer: the request, the idle cycles in front of it, and whether to
   // hold it back until every outstanding result has come
   typedef struct {
      fntt_pkg::req_type item;
      int unsigned       gap;
      bit                drain;
   } cmd_slot_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              start = 1'b0;
   logic              busy;
   fntt_pkg::req_type req_data = '0;
   logic              rsp_strobe;
   fntt_pkg::rsp_type rsp_data;

   forward_ntt_mod_3329_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #1 clock = ~clock;

   // --------------------------------------------------------------------------------------
   // Prediction: own copy of the store and of the twiddle table
   // --------------------------------------------------------------------------------------
   logic [fntt_pkg::COEF_W-1:0] coef_model [fntt_pkg::NUM_COEFS];
   int                          twiddle    [fntt_pkg::NUM_ZETAS];
   fntt_pkg::rsp_type           expected_rsp_q [$];

   function automatic int bit_reverse7(input int v);
      int r;
      r = 0;
      for (int b = 0; b < 7; b++) r = (r << 1) | ((v >> b) & 1);
      return r;
   endfunction

   // twiddle k = 17^BitRev7(k) mod q
   task automatic build_twiddles();
      int p;
      for (int k = 0; k < fntt_pkg::NUM_ZETAS; k++) begin
         p = 1;
         repeat (bit_reverse7(k)) p = (p * 17) % Q_MOD;
         twiddle[k] = p;
      end
   endtask

   // in-place Cooley-Tukey pass, lengths 128 down to 2, twiddle index starting at 1
   task automatic forward_transform();
      int k, zeta, a, b, t;
      k = 1;
      for (int len = fntt_pkg::NUM_COEFS / 2; len >= 2; len = len / 2) begin
         for (int base = 0; base < fntt_pkg::NUM_COEFS; base += 2 * len) begin
            zeta = twiddle[k % fntt_pkg::NUM_ZETAS];
            k++;
            for (int j = base; j < base + len; j++) begin
               a = int'(coef_model[j]);
               b = int'(coef_model[j + len]);
               t = (zeta * b) % Q_MOD;
               coef_model[j + len] = 12'((a + Q_MOD - t) % Q_MOD);
               coef_model[j]       = 12'((a + t) % Q_MOD);
            end
         end
      end
   endtask

   task automatic predict_transfer(input fntt_pkg::req_type r);
      fntt_pkg::rsp_type want;
      unique case (r.cmd)
         fntt_pkg::CMD_WRITE: coef_model[r.index] = 12'(int'(r.coef_in) % Q_MOD);
         fntt_pkg::CMD_RUN: begin
            forward_transform();
            want.coef_out = '0;
            want.is_done  = 1'b1;
            expected_rsp_q.push_back(want);
         end
         fntt_pkg::CMD_READ: begin
            want.coef_out = coef_model[r.index];
            want.is_done  = 1'b0;
            expected_rsp_q.push_back(want);
         end
         default: ; // unused code: store untouched, no result
      endcase
   endtask

   // --------------------------------------------------------------------------------------
   // Stimulus plan
   // --------------------------------------------------------------------------------------
   cmd_slot_type cmd_plan_q [$];
   int           calm_left;
   int           counted_items;
   longint       cycle_budget;
   longint       cycle_limit;

   // bias coefficients toward zero, the top code, q-1 and the band that needs reduction
   function automatic logic [fntt_pkg::COEF_W-1:0] pick_coef();
      unique case ($urandom_range(0, 7))
         0:       return '0;
         1:       return 12'hFFF;
         2:       return 12'(Q_MOD - 1);
         3:       return 12'(Q_MOD + $urandom_range(0, 4095 - Q_MOD));
         default: return 12'($urandom_range(0, 4095));
      endcase
   endfunction

   task automatic add_item(input logic [1:0] cmd, input int idx,
                           input logic [fntt_pkg::COEF_W-1:0] coef, input bit drain);
      cmd_slot_type s;
      int           r;
      s.item.cmd     = cmd;
      s.item.index   = idx[fntt_pkg::ADDR_W-1:0];
      s.item.coef_in = coef;
      s.drain        = drain;
      // mostly short gaps, a few long ones, and now and then a stretch of back-to-back transfers
      if (calm_left > 0) begin
         s.gap = 0;
         calm_left--;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 3) begin
            calm_left = $urandom_range(20, 80);
            s.gap     = 0;
         end else if (r < 50) s.gap = 0;
         else if (r < 88) s.gap = $urandom_range(1, 3);
         else if (r < 97) s.gap = $urandom_range(4, 12);
         else s.gap = $urandom_range(20, 60);
      end
      cmd_plan_q.push_back(s);
      if (cmd != CMD_UNUSED) counted_items++;
      cycle_budget += s.gap + ((cmd == fntt_pkg::CMD_RUN) ? RUN_CYCLES : 4);
   endtask

   task automatic plan_directed();
      // fresh store reads zero; a transform of all zeros stays zero
      add_item(fntt_pkg::CMD_READ, 0, '0, 0);
      add_item(fntt_pkg::CMD_READ, 255, 12'hFFF, 0);
      add_item(fntt_pkg::CMD_RUN, 0, '0, 0);
      add_item(fntt_pkg::CMD_READ, 128, '0, 0);
      // unused code with all bits set must leave the store alone
      add_item(CMD_UNUSED, 255, 12'hFFF, 0);
      add_item(fntt_pkg::CMD_READ, 255, '0, 0);
      // extremes of index and value, including values that need reduction
      add_item(fntt_pkg::CMD_WRITE, 0, 12'hFFF, 0);
      add_item(fntt_pkg::CMD_WRITE, 255, 12'(Q_MOD), 0);
      add_item(fntt_pkg::CMD_WRITE, 128, 12'(Q_MOD - 1), 0);
      add_item(fntt_pkg::CMD_WRITE, 1, '0, 0);
      add_item(fntt_pkg::CMD_WRITE, 127, 12'h800, 0);
      add_item(fntt_pkg::CMD_WRITE, 64, 12'd1, 0);
      add_item(fntt_pkg::CMD_READ, 0, '0, 0);
      add_item(fntt_pkg::CMD_READ, 255, '0, 0);
      add_item(fntt_pkg::CMD_READ, 128, '0, 0);
      // transform after letting everything settle
      add_item(fntt_pkg::CMD_RUN, 0, '0, 1);
      add_item(fntt_pkg::CMD_READ, 0, '0, 0);
      add_item(fntt_pkg::CMD_READ, 1, '0, 0);
      add_item(fntt_pkg::CMD_READ, 64, '0, 0);
      add_item(fntt_pkg::CMD_READ, 128, '0, 0);
      add_item(fntt_pkg::CMD_READ, 255, '0, 0);
      add_item(CMD_UNUSED, 0, '0, 0);
      add_item(fntt_pkg::CMD_READ, 0, '0, 0);
   endtask

   task automatic plan_random();
      int n, pick;
      while (counted_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) < 7) begin
            // load a polynomial, transform it, read parts of it back
            if ($urandom_range(0, 11) == 0) begin
               for (int i = 0; i < fntt_pkg::NUM_COEFS; i++)
                  add_item(fntt_pkg::CMD_WRITE, i, pick_coef(), 0);
            end else begin
               n = $urandom_range(4, 60);
               repeat (n) begin
                  if ($urandom_range(0, 29) == 0)
                     add_item(CMD_UNUSED, $urandom_range(0, 255), pick_coef(), 0);
                  else
                     add_item(fntt_pkg::CMD_WRITE, $urandom_range(0, 255), pick_coef(), 0);
               end
            end
            add_item(fntt_pkg::CMD_RUN, $urandom_range(0, 255), pick_coef(),
                     $urandom_range(0, 3) == 0);
            n = $urandom_range(4, 40);
            repeat (n) begin
               if ($urandom_range(0, 9) == 0)
                  add_item(fntt_pkg::CMD_WRITE, $urandom_range(0, 255), pick_coef(), 0);
               else
                  add_item(fntt_pkg::CMD_READ, $urandom_range(0, 255), pick_coef(), 0);
            end
         end else begin
            // loose mix of every code, runs kept rare
            n = $urandom_range(10, 40);
            repeat (n) begin
               pick = $urandom_range(0, 99);
               if (pick < 45)
                  add_item(fntt_pkg::CMD_WRITE, $urandom_range(0, 255), pick_coef(), 0);
               else if (pick < 90)
                  add_item(fntt_pkg::CMD_READ, $urandom_range(0, 255), pick_coef(), 0);
               else if (pick < 94)
                  add_item(fntt_pkg::CMD_RUN, $urandom_range(0, 255), pick_coef(), 0);
               else
                  add_item(CMD_UNUSED, $urandom_range(0, 255), pick_coef(), 0);
            end
         end
      end
   endtask

   // --------------------------------------------------------------------------------------
   // Driver: present one planned request at a time, hold it until the transfer
   // --------------------------------------------------------------------------------------
   cmd_slot_type staged_cmd;
   bit           have_staged = 1'b0;
   int           idle_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         for (int i = 0; i < fntt_pkg::NUM_COEFS; i++) coef_model[i] = '0;
      end else if (start && busy) begin
         // hold the request until the unit frees up
      end else begin
         if (start) predict_transfer(req_data);
         if (!have_staged && cmd_plan_q.size() != 0) begin
            staged_cmd  = cmd_plan_q.pop_front();
            have_staged = 1'b1;
            idle_left   = staged_cmd.gap;
         end
         if (have_staged && idle_left == 0 &&
             (!staged_cmd.drain || expected_rsp_q.size() == 0)) begin
            req_data    <= staged_cmd.item;
            start       <= 1'b1;
            have_staged = 1'b0;
         end else begin
            start <= 1'b0;
            if (idle_left > 0) idle_left--;
         end
      end
   end

   // --------------------------------------------------------------------------------------
   // Monitor: every strobe is a transfer; compare with the oldest expectation
   // --------------------------------------------------------------------------------------
   int mismatch_count = 0;

   task automatic note_mismatch(input string what, input int want,
                                input logic [fntt_pkg::COEF_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
         $display("mismatch %s: expected %0d, got %0d", what, want, got);
   endtask

   always @(posedge clock) begin
      fntt_pkg::rsp_type want;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (expected_rsp_q.size() == 0) begin
            note_mismatch("unexpected result coef_out", 0, rsp_data.coef_out);
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_data.coef_out !== want.coef_out)
               note_mismatch("coef_out", int'(want.coef_out), rsp_data.coef_out);
            if (rsp_data.is_done !== want.is_done)
               note_mismatch("is_done", int'(want.is_done),
                             {{(fntt_pkg::COEF_W-1){1'b0}}, rsp_data.is_done});
         end
      end
   end

   // --------------------------------------------------------------------------------------
   // Watchdog: the budget covers the clearing sweep, every gap and every transfer, times four
   // --------------------------------------------------------------------------------------
   longint cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > cycle_limit) begin
         $display("forward_ntt_mod_3329_unit regression: fail");
         $finish;
      end
   end

   // --------------------------------------------------------------------------------------
   // Sequence: plan, reset, wait for the plan to drain, report
   // --------------------------------------------------------------------------------------
   initial begin
      reset          = 1'b1;
      calm_left      = 0;
      counted_items  = 0;
      cycle_budget   = 0;
      build_twiddles();
      plan_directed();
      plan_random();
      cycle_limit = 4 * (cycle_budget + 2 * fntt_pkg::NUM_COEFS + 64);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // sample at the falling edge so the driver and monitor have settled
      do @(negedge clock);
      while (cmd_plan_q.size() != 0 || have_staged || start || expected_rsp_q.size() != 0);
      repeat (20) @(posedge clock);

      if (mismatch_count == 0 && expected_rsp_q.size() == 0)
         $display("forward_ntt_mod_3329_unit regression: pass");
      else
         $display("forward_ntt_mod_3329_unit regression: fail");
      $finish;
   end

endmodule
